FILE: sv/ncsc_pkg.sv
// Types and constants shared by the NMEA sentence checksum checker.
`default_nettype none

package ncsc_pkg;

  localparam int unsigned PrefixLen = 6;

  localparam logic [PrefixLen-1:0][7:0] GgaPrefix = {"A", "G", "G", "N", "G", "$"};
  localparam logic [PrefixLen-1:0][7:0] RmcPrefix = {"C", "M", "R", "N", "G", "$"};

  localparam logic [7:0] CharStar       = 8'h2a;
  localparam logic [7:0] DigitOffset    = 8'h30;
  localparam logic [7:0] UpperHexOffset = 8'h37;
  localparam logic [7:0] LowerHexOffset = 8'h57;
  localparam logic [7:0] NoStarSum      = 8'd255;

  typedef enum logic [1:0] {
    KindGga     = 2'd0,
    KindRmc     = 2'd1,
    KindUnknown = 2'd2
  } sentence_kind_e;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_sentence;
  } in_item_t;

  typedef struct packed {
    sentence_kind_e sentence_kind;
    logic           checksum_ok;
    logic [7:0]     computed_sum;
    logic [7:0]     received_sum;
    logic           crc_error_flag;
  } out_item_t;

  typedef struct packed {
    sentence_kind_e sentence_kind;
    logic [7:0]     computed_sum;
    logic [7:0]     received_sum;
  } sentence_rec_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= "0" && c <= "9") begin
      v = c - DigitOffset;
    end else if (c >= "A" && c <= "F") begin
      v = c - UpperHexOffset;
    end else if (c >= "a" && c <= "f") begin
      v = c - LowerHexOffset;
    end
    return v[3:0];
  endfunction

endpackage

`default_nettype wire

FILE: sv/ncsc_front.sv
// Front end: parses sentence characters and emits one record per sentence.
`default_nettype none

module ncsc_front (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire ncsc_pkg::in_item_t    in_item_i,
  input  wire logic                  rec_full_i,
  output logic                       rec_push_o,
  output ncsc_pkg::sentence_rec_t    rec_o
);

  logic [2:0] pos_q, pos_d;
  logic [1:0] match_q, match_d;
  logic [7:0] xor_q, xor_d;
  logic       star_q, star_d;
  logic [1:0] digits_q, digits_d;
  logic [7:0] recv_q, recv_d;

  logic       accept;
  logic       first;
  logic [7:0] c;
  logic [3:0] d;

  assign in_stall_o = rec_full_i;
  assign accept     = in_valid_i && !rec_full_i;
  assign c          = in_item_i.char_byte;
  assign first      = (pos_q == 3'd0);
  assign d          = ncsc_pkg::hex_value(c);

  always_comb begin
    pos_d      = pos_q;
    match_d    = match_q;
    xor_d      = xor_q;
    star_d     = star_q;
    digits_d   = digits_q;
    recv_d     = recv_q;
    rec_push_o = 1'b0;
    rec_o      = '{sentence_kind: ncsc_pkg::KindUnknown, computed_sum: 8'd0,
                   received_sum: 8'd0};
    if (accept) begin
      if (pos_q < 3'(ncsc_pkg::PrefixLen)) begin
        if (c != ncsc_pkg::GgaPrefix[pos_q]) begin
          match_d[0] = 1'b0;
        end
        if (c != ncsc_pkg::RmcPrefix[pos_q]) begin
          match_d[1] = 1'b0;
        end
        pos_d = pos_q + 3'd1;
      end
      if (!first) begin
        if (!star_q) begin
          if (c == ncsc_pkg::CharStar) begin
            star_d = 1'b1;
          end else begin
            xor_d = xor_q ^ c;
          end
        end else if (digits_q < 2'd2) begin
          if (digits_q == 2'd0) begin
            recv_d = {d, 4'd0};
          end else begin
            recv_d = recv_q | {4'd0, d};
          end
          digits_d = digits_q + 2'd1;
        end
      end
      if (in_item_i.end_of_sentence) begin
        rec_push_o = 1'b1;
        if (pos_d >= 3'(ncsc_pkg::PrefixLen)) begin
          if (match_d[0]) begin
            rec_o.sentence_kind = ncsc_pkg::KindGga;
          end else if (match_d[1]) begin
            rec_o.sentence_kind = ncsc_pkg::KindRmc;
          end
        end
        if (rec_o.sentence_kind != ncsc_pkg::KindUnknown) begin
          if (star_d) begin
            rec_o.computed_sum = xor_d;
            rec_o.received_sum = recv_d;
          end else begin
            rec_o.received_sum = ncsc_pkg::NoStarSum;
          end
        end
        pos_d    = 3'd0;
        match_d  = 2'b11;
        xor_d    = 8'd0;
        star_d   = 1'b0;
        digits_d = 2'd0;
        recv_d   = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 3'd0;
      match_q  <= 2'b11;
      xor_q    <= 8'd0;
      star_q   <= 1'b0;
      digits_q <= 2'd0;
      recv_q   <= 8'd0;
    end else begin
      pos_q    <= pos_d;
      match_q  <= match_d;
      xor_q    <= xor_d;
      star_q   <= star_d;
      digits_q <= digits_d;
      recv_q   <= recv_d;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ncsc_fifo.sv
// Short record queue between the front end and the back end.
`default_nettype none

module ncsc_fifo #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    push_i,
  input  wire ncsc_pkg::sentence_rec_t wdata_i,
  input  wire logic                    pop_i,
  output ncsc_pkg::sentence_rec_t      rdata_o,
  output logic                         full_o,
  output logic                         empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  ncsc_pkg::sentence_rec_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : wptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : rptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("Record pushed into a full queue.");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("Record popped from an empty queue.");

endmodule

`default_nettype wire

FILE: sv/ncsc_back.sv
// Back end: checks each record, keeps the sticky error flag and holds the result.
`default_nettype none

module ncsc_back (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    rec_empty_i,
  input  wire ncsc_pkg::sentence_rec_t rec_i,
  output logic                         rec_pop_o,
  output logic                         out_valid_o,
  input  wire logic                    out_stall_i,
  output ncsc_pkg::out_item_t          out_item_o
);

  logic                valid_q, valid_d;
  logic                sticky_q, sticky_d;
  ncsc_pkg::out_item_t out_q, out_d;
  logic                ok;
  logic                known;

  assign known     = (rec_i.sentence_kind != ncsc_pkg::KindUnknown);
  assign ok        = known && (rec_i.computed_sum == rec_i.received_sum);
  assign rec_pop_o = !rec_empty_i && (!valid_q || !out_stall_i);

  always_comb begin
    valid_d  = valid_q;
    sticky_d = sticky_q;
    out_d    = out_q;
    if (valid_q && !out_stall_i) begin
      valid_d = 1'b0;
    end
    if (rec_pop_o) begin
      if (known) begin
        sticky_d = !ok;
      end
      valid_d = 1'b1;
      out_d   = '{sentence_kind: rec_i.sentence_kind, checksum_ok: ok,
                  computed_sum: rec_i.computed_sum, received_sum: rec_i.received_sum,
                  crc_error_flag: sticky_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      sticky_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      sticky_q <= sticky_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = out_q;

  a_unknown_keeps_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_pop_o && !known |=> sticky_q == $past(sticky_q))
    else $error("Unrecognized sentence changed the sticky flag.");

  a_flag_tracks_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_q.sentence_kind != ncsc_pkg::KindUnknown
      |-> out_q.crc_error_flag == !out_q.checksum_ok)
    else $error("Sticky flag disagrees with the checksum result.");

  a_unknown_not_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && out_q.sentence_kind == ncsc_pkg::KindUnknown |-> !out_q.checksum_ok)
    else $error("Unrecognized sentence reported a good checksum.");

endmodule

`default_nettype wire

FILE: sv/nmea_sentence_checksum_checker_unit.sv
// Top level of the NMEA sentence checksum checker.
//
//   Channel | Direction | Handshake                 | Item
//   in      | input     | in_valid_i / in_stall_o   | one sentence character
//   out     | output    | out_valid_o / out_stall_i | one sentence result
//
// One character is accepted every cycle while the record queue has room.
// A sentence's record is pushed into the queue when its final character is accepted;
// its result is offered from the back end's output register once the record is popped.
// The queue holds QueueDepth sentence records; when it is full the input stalls.
// Reset clears the parser, the queue, the output valid bit and the sticky flag.
`default_nettype none

module nmea_sentence_checksum_checker_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ncsc_pkg::in_item_t  in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ncsc_pkg::out_item_t      out_item_o
);

  ncsc_pkg::sentence_rec_t push_rec;
  ncsc_pkg::sentence_rec_t pop_rec;
  logic                    push;
  logic                    pop;
  logic                    full;
  logic                    empty;

  ncsc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .rec_full_i (full),
    .rec_push_o (push),
    .rec_o      (push_rec)
  );

  ncsc_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_rec),
    .pop_i   (pop),
    .rdata_o (pop_rec),
    .full_o  (full),
    .empty_o (empty)
  );

  ncsc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_empty_i (empty),
    .rec_i       (pop_rec),
    .rec_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire

FILE: bench/tb_nmea_sentence_checksum_checker_unit.sv
// Testbench for the NMEA sentence checksum checker: directed and random sentences checked against a predictor.
`timescale 1ns / 1ps

module tb_nmea_sentence_checksum_checker_unit;

  localparam logic [47:0] GGA_TEXT = "$GNGGA";
  localparam logic [47:0] RMC_TEXT = "$GNRMC";
  localparam int unsigned PREFIX_CHARS = 6;
  localparam int unsigned STIM_ITEMS = 1800;
  localparam int unsigned DIRECTED_RESULTS = 5;
  localparam int unsigned LONG_HOLD = 300;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned TAIL_CYCLES = 10;

  typedef struct packed {
    logic               drain_first;
    logic               no_gap;
    ncsc_pkg::in_item_t item;
  } char_stim_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  ncsc_pkg::in_item_t  in_item = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  ncsc_pkg::out_item_t out_item;

  char_stim_t          char_stim_q[$];
  ncsc_pkg::out_item_t sentence_results_q[$];
  int unsigned         stim_items = 0;
  int unsigned         errors = 0;

  // Predictor state of the sentence parser.
  logic [2:0] char_pos = '0;
  logic [1:0] prefix_live = 2'b11;
  logic [7:0] running_xor = '0;
  logic       star_seen = 1'b0;
  logic [1:0] digits_taken = '0;
  logic [7:0] rx_sum = '0;
  logic       crc_sticky = 1'b0;

  int unsigned send_gap = 0;
  char_stim_t  next_char;

  int unsigned         hold_cnt = 0;
  int unsigned         results_seen = 0;
  int unsigned         stall_len;
  logic                rx_calm = 1'b0;
  logic                long_hold_done = 1'b0;
  ncsc_pkg::out_item_t want;

  int unsigned quiet = 0;

  nmea_sentence_checksum_checker_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input logic lower);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return (lower ? 8'h57 : 8'h37) + 8'(v);
  endfunction

  task automatic push_char(input logic [7:0] c, input logic eos, input logic drain,
                           input logic calm);
    char_stim_t s;
    s.drain_first = drain;
    s.no_gap = calm;
    s.item.char_byte = c;
    s.item.end_of_sentence = eos;
    char_stim_q.push_back(s);
    stim_items++;
  endtask

  task automatic push_text(input string text);
    for (int i = 0; i < text.len(); i++) begin
      push_char(text[i], i == text.len() - 1, 1'b0, 1'b0);
    end
  endtask

  // Advances the parser by one character and queues the sentence result on the final one.
  task automatic scan_sentence_char(input ncsc_pkg::in_item_t it);
    logic [7:0]               c;
    logic [7:0]               d;
    logic                     first;
    ncsc_pkg::sentence_kind_e kind;
    ncsc_pkg::out_item_t      r;
    c = it.char_byte;
    first = (char_pos == 0);
    if (char_pos < PREFIX_CHARS) begin
      if (c != GGA_TEXT[8*(5-char_pos) +: 8]) prefix_live[0] = 1'b0;
      if (c != RMC_TEXT[8*(5-char_pos) +: 8]) prefix_live[1] = 1'b0;
      char_pos = char_pos + 3'd1;
    end
    if (!first) begin
      if (!star_seen) begin
        if (c == "*") star_seen = 1'b1;
        else running_xor = running_xor ^ c;
      end else if (digits_taken < 2) begin
        if (c >= "0" && c <= "9") d = c - 8'h30;
        else if (c >= "A" && c <= "F") d = c - 8'h37;
        else if (c >= "a" && c <= "f") d = c - 8'h57;
        else d = 8'h00;
        if (digits_taken == 0) rx_sum = {d[3:0], 4'h0};
        else rx_sum[3:0] = d[3:0];
        digits_taken = digits_taken + 2'd1;
      end
    end
    if (it.end_of_sentence) begin
      kind = ncsc_pkg::KindUnknown;
      if (char_pos >= PREFIX_CHARS) begin
        if (prefix_live[0]) kind = ncsc_pkg::KindGga;
        else if (prefix_live[1]) kind = ncsc_pkg::KindRmc;
      end
      r = '0;
      r.sentence_kind = kind;
      if (kind != ncsc_pkg::KindUnknown) begin
        r.computed_sum = star_seen ? running_xor : 8'h00;
        r.received_sum = star_seen ? rx_sum : 8'hff;
        r.checksum_ok = (r.computed_sum == r.received_sum);
        crc_sticky = !r.checksum_ok;
      end
      r.crc_error_flag = crc_sticky;
      sentence_results_q.push_back(r);
      char_pos = '0;
      prefix_live = 2'b11;
      running_xor = '0;
      star_seen = 1'b0;
      digits_taken = '0;
      rx_sum = '0;
    end
  endtask

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item <= '0;
      send_gap <= 0;
      char_pos = '0;
      prefix_live = 2'b11;
      running_xor = '0;
      star_seen = 1'b0;
      digits_taken = '0;
      rx_sum = '0;
      crc_sticky = 1'b0;
    end else begin
      if (in_valid && !in_stall) scan_sentence_char(in_item);
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (char_stim_q.size() != 0 &&
                   !(char_stim_q[0].drain_first && sentence_results_q.size() != 0)) begin
        next_char = char_stim_q.pop_front();
        in_item <= next_char.item;
        in_valid <= 1'b1;
        send_gap <= next_char.no_gap ? 0 : idle_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt <= 0;
      results_seen <= 0;
      rx_calm <= 1'b0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (sentence_results_q.size() == 0) begin
          $error("unexpected result: kind %0d", out_item.sentence_kind);
          errors++;
        end else begin
          want = sentence_results_q.pop_front();
          if (out_item.sentence_kind !== want.sentence_kind) begin
            $error("sentence_kind: expected %0d, got %0d", want.sentence_kind,
                   out_item.sentence_kind);
            errors++;
          end
          if (out_item.checksum_ok !== want.checksum_ok) begin
            $error("checksum_ok: expected %0d, got %0d", want.checksum_ok, out_item.checksum_ok);
            errors++;
          end
          if (out_item.computed_sum !== want.computed_sum) begin
            $error("computed_sum: expected %0h, got %0h", want.computed_sum,
                   out_item.computed_sum);
            errors++;
          end
          if (out_item.received_sum !== want.received_sum) begin
            $error("received_sum: expected %0h, got %0h", want.received_sum,
                   out_item.received_sum);
            errors++;
          end
          if (out_item.crc_error_flag !== want.crc_error_flag) begin
            $error("crc_error_flag: expected %0d, got %0d", want.crc_error_flag,
                   out_item.crc_error_flag);
            errors++;
          end
        end
        results_seen <= results_seen + 1;
      end
      if ($urandom_range(0, 299) == 0) rx_calm <= !rx_calm;
      stall_len = idle_len();
      if (out_valid && !out_stall && results_seen == DIRECTED_RESULTS - 1 && !long_hold_done) begin
        out_stall <= 1'b1;
        hold_cnt <= LONG_HOLD;
        long_hold_done <= 1'b1;
      end else if (hold_cnt != 0) begin
        out_stall <= 1'b1;
        hold_cnt <= hold_cnt - 1;
      end else if (rx_calm || stall_len == 0) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b1;
        hold_cnt <= stall_len - 1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAIL nmea_sentence_checksum_checker_unit");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [7:0]  chars[$];
    logic [7:0]  sum;
    logic [7:0]  c;
    logic [47:0] prefix;
    int unsigned cat, keep_len, body_len, n_digits, extra, next_drain;
    logic        use_rmc, mutate, with_star, bad_digits, lower, calm, drain;

    push_text("$GNGGA*48");
    push_text("$GNRMC");
    push_text("$GN*");
    push_char(8'hff, 1'b1, 1'b0, 1'b0);
    push_char(8'h00, 1'b1, 1'b0, 1'b0);
    // Back-to-back one-character sentences fill the block while the receiver holds off.
    for (int i = 0; i < 40; i++) push_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b1);

    calm = 1'b0;
    drain = 1'b1;
    next_drain = stim_items + 200;
    while (stim_items < STIM_ITEMS) begin
      chars.delete();
      cat = $urandom_range(0, 19);
      use_rmc = $urandom_range(0, 1);
      keep_len = PREFIX_CHARS;
      mutate = 1'b0;
      with_star = 1'b1;
      n_digits = 2;
      bad_digits = 1'b0;
      lower = $urandom_range(0, 1);
      body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 8);
      extra = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      unique case (cat)
        14: mutate = 1'b1;
        15: with_star = 1'b0;
        16: n_digits = $urandom_range(0, 1);
        17: bad_digits = 1'b1;
        18: begin
          keep_len = $urandom_range(1, 5);
          body_len = 0;
          with_star = 1'b0;
          extra = 0;
        end
        19: begin
          keep_len = 0;
          body_len = $urandom_range(1, 12);
          with_star = 1'b0;
          extra = 0;
        end
        default: ;
      endcase
      prefix = use_rmc ? RMC_TEXT : GGA_TEXT;
      for (int i = 0; i < keep_len; i++) chars.push_back(prefix[8*(5-i) +: 8]);
      if (mutate) chars[$urandom_range(0, 5)] = 8'($urandom_range(0, 255));
      for (int i = 0; i < body_len; i++) begin
        if (cat == 19) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          c = 8'($urandom_range(32, 126));
          if (c == "*") c = ",";
        end
        chars.push_back(c);
      end
      if (with_star) begin
        sum = 8'h00;
        for (int i = 1; i < chars.size(); i++) sum = sum ^ chars[i];
        if ($urandom_range(0, 5) == 0) sum = sum ^ (8'd1 << $urandom_range(0, 7));
        chars.push_back("*");
        for (int i = 0; i < n_digits; i++) begin
          if (bad_digits) chars.push_back(8'($urandom_range(0, 255)));
          else chars.push_back(hex_char(i == 0 ? sum[7:4] : sum[3:0], lower));
        end
      end
      for (int i = 0; i < extra; i++) chars.push_back(8'($urandom_range(0, 255)));
      for (int i = 0; i < chars.size(); i++) begin
        push_char(chars[i], i == chars.size() - 1, drain && i == 0, calm);
      end
      drain = 1'b0;
      if (stim_items >= next_drain) begin
        drain = 1'b1;
        calm = ($urandom_range(0, 2) == 0);
        next_drain = stim_items + $urandom_range(150, 300);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    do @(posedge clk);
    while (char_stim_q.size() != 0 || in_valid || sentence_results_q.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0 && sentence_results_q.size() == 0) begin
      $display("PASS nmea_sentence_checksum_checker_unit");
    end else begin
      $display("FAIL nmea_sentence_checksum_checker_unit");
    end
    $finish;
  end

endmodule

FILE: filelist.f
sv/ncsc_pkg.sv
sv/ncsc_front.sv
sv/ncsc_fifo.sv
sv/ncsc_back.sv
sv/nmea_sentence_checksum_checker_unit.sv
bench/tb_nmea_sentence_checksum_checker_unit.sv
